[src/prl_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// prl_pkg
// Shared types, widths and arithmetic step functions for the pose leveler.
// ----------------------------------------------------------------------------
package prl_pkg;

  localparam int FRAC_BITS   = 14;
  localparam int DATA_W      = 16;
  localparam int SQ_W        = 2 * DATA_W;
  localparam int ROOT_W      = SQ_W / 2;
  localparam int REM_W       = ROOT_W + 4;
  localparam int SQRT_PER    = 2;
  localparam int SQRT_STAGES = (ROOT_W + SQRT_PER - 1) / SQRT_PER;
  localparam int NUM_W       = DATA_W + FRAC_BITS;
  localparam int DIV_PER     = 3;
  localparam int DIV_STAGES  = (NUM_W + DIV_PER - 1) / DIV_PER;
  localparam int NUM_PAD     = DIV_STAGES * DIV_PER;
  localparam int DREM_W      = ROOT_W + 1;
  localparam int SAT_W       = 64;
  localparam int PROD_W      = 2 * DATA_W;

  localparam logic [31:0] THRESH_RESET = 32'd26844;

  typedef logic signed [DATA_W-1:0] ent_t;

  typedef struct packed {
    logic mode;
    ent_t right_x;
    ent_t right_y;
    ent_t right_z;
    ent_t up_x;
    ent_t up_y;
    ent_t up_z;
    ent_t back_x;
    ent_t back_y;
    ent_t back_z;
  } in_t;

  typedef struct packed {
    ent_t new_right_x;
    ent_t new_right_y;
    ent_t new_right_z;
    ent_t new_up_x;
    ent_t new_up_y;
    ent_t new_up_z;
    ent_t new_back_x;
    ent_t new_back_y;
    ent_t new_back_z;
    logic leveled;
  } out_t;

  typedef struct packed {
    logic [SQ_W-1:0]   x;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sqrt_st_t;

  typedef struct packed {
    logic [NUM_PAD-1:0] num;
    logic [DREM_W-1:0]  rem;
    logic [NUM_PAD-1:0] quo;
  } div_st_t;

  typedef struct packed {
    logic v;
    logic lev;
    in_t  item;
  } side_t;

  function automatic ent_t sat16(logic signed [SAT_W-1:0] v);
    logic signed [SAT_W-1:0] hi;
    logic signed [SAT_W-1:0] lo;
    hi = SAT_W'(signed'({1'b0, {(DATA_W-1){1'b1}}}));
    lo = -hi - SAT_W'(1);
    if (v > hi) return ent_t'(hi);
    if (v < lo) return ent_t'(lo);
    return ent_t'(v);
  endfunction

  localparam ent_t UNIT_Q = sat16(SAT_W'(64'sd1 <<< FRAC_BITS));

  // one result bit of the square root, two radicand bits consumed
  function automatic sqrt_st_t sqrt_iter(sqrt_st_t s);
    sqrt_st_t n;
    logic [REM_W-1:0] trial;
    n.rem  = {s.rem[REM_W-3:0], s.x[SQ_W-1 -: 2]};
    n.x    = s.x << 2;
    trial  = REM_W'({s.root, 2'b01});
    if (n.rem >= trial) begin
      n.rem  = n.rem - trial;
      n.root = {s.root[ROOT_W-2:0], 1'b1};
    end else begin
      n.root = {s.root[ROOT_W-2:0], 1'b0};
    end
    return n;
  endfunction

  // one quotient bit of restoring division
  function automatic div_st_t div_iter(div_st_t s, logic [ROOT_W-1:0] den);
    div_st_t n;
    n.rem = {s.rem[DREM_W-2:0], s.num[NUM_PAD-1]};
    n.num = s.num << 1;
    if (n.rem >= DREM_W'(den)) begin
      n.rem = n.rem - DREM_W'(den);
      n.quo = {s.quo[NUM_PAD-2:0], 1'b1};
    end else begin
      n.quo = {s.quo[NUM_PAD-2:0], 1'b0};
    end
    return n;
  endfunction

endpackage
`default_nettype wire

[src/pose_rotation_leveler_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pose_rotation_leveler_top
// Levels a rotation: keeps heading only, or removes roll only.
// ----------------------------------------------------------------------------
//  channel  signals                         direction
//  in       in_valid/in_ready/in_data       request in
//  out      out_valid/out_ready/out_data    result out
//  cfg      cfg_valid/cfg_ready/cfg_data    threshold write
//
//  one request per cycle while the pipe advances; the path runs through stages a
//  and b, the square root and divider pipes, stages c and d, and the output register
//  the whole pipe advances when the output register is empty or taken
//  rst clears valid bits and loads the threshold reset value
// ----------------------------------------------------------------------------
module pose_rotation_leveler_top (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire prl_pkg::in_t   in_data,
  output logic                out_valid,
  input  wire logic           out_ready,
  output prl_pkg::out_t       out_data,
  input  wire logic           cfg_valid,
  output logic                cfg_ready,
  input  wire logic [31:0]    cfg_data
);

  localparam int LAT = prl_pkg::SQRT_STAGES + prl_pkg::DIV_STAGES;

  logic        en;
  logic [31:0] thresh;

  assign en        = !out_valid || out_ready;
  assign in_ready  = en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      thresh <= prl_pkg::THRESH_RESET;
    end else if (cfg_valid) begin
      thresh <= cfg_data;
    end
  end

  // stage a: squares
  logic                            a_v;
  prl_pkg::in_t                    a_item;
  logic signed [prl_pkg::SQ_W-1:0] a_sqx, a_sqz;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
    end else if (en) begin
      a_v <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_item <= in_data;
      a_sqx  <= in_data.back_x * in_data.back_x;
      a_sqz  <= in_data.back_z * in_data.back_z;
    end
  end

  // stage b: horizontal length squared and threshold check
  logic                     b_v, b_lev;
  prl_pkg::in_t             b_item;
  logic [prl_pkg::SQ_W-1:0] b_s, s_sum;

  assign s_sum = prl_pkg::SQ_W'(unsigned'(a_sqx)) + prl_pkg::SQ_W'(unsigned'(a_sqz));

  always_ff @(posedge clk) begin
    if (rst) begin
      b_v <= 1'b0;
    end else if (en) begin
      b_v <= a_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_item <= a_item;
      b_s    <= s_sum;
      b_lev  <= s_sum > thresh;
    end
  end

  // side line carrying the request past the root and divider pipes
  prl_pkg::side_t side[LAT];

  for (genvar i = 0; i < LAT; i++) begin : g_side
    prl_pkg::side_t prev;
    assign prev = (i == 0) ? prl_pkg::side_t'{v: b_v, lev: b_lev, item: b_item}
                           : side[(i == 0) ? 0 : i-1];
    always_ff @(posedge clk) begin
      if (en) begin
        side[i].lev  <= prev.lev;
        side[i].item <= prev.item;
      end
      if (rst) begin
        side[i].v <= 1'b0;
      end else if (en) begin
        side[i].v <= prev.v;
      end
    end
  end

  logic [prl_pkg::ROOT_W-1:0]  len;
  logic [prl_pkg::DATA_W-1:0]  mag_x, mag_z;
  logic [prl_pkg::NUM_PAD-1:0] num_x, num_z, quo_x, quo_z;
  prl_pkg::in_t                mid;

  prl_isqrt u_isqrt (
    .clk      (clk),
    .en       (en),
    .radicand (b_s),
    .root     (len)
  );

  assign mid   = side[prl_pkg::SQRT_STAGES-1].item;
  assign mag_x = mid.back_x[prl_pkg::DATA_W-1] ? unsigned'(-mid.back_x) : unsigned'(mid.back_x);
  assign mag_z = mid.back_z[prl_pkg::DATA_W-1] ? unsigned'(-mid.back_z) : unsigned'(mid.back_z);
  assign num_x = prl_pkg::NUM_PAD'(mag_x) << prl_pkg::FRAC_BITS;
  assign num_z = prl_pkg::NUM_PAD'(mag_z) << prl_pkg::FRAC_BITS;

  prl_div u_div_x (
    .clk (clk),
    .en  (en),
    .num (num_x),
    .den (len),
    .quo (quo_x)
  );

  prl_div u_div_z (
    .clk (clk),
    .en  (en),
    .num (num_z),
    .den (len),
    .quo (quo_z)
  );

  // stage c: signs and saturation of the normalized entries
  prl_pkg::side_t               last;
  logic signed [prl_pkg::SAT_W-1:0] qx, qz;
  logic                         c_v, c_lev;
  prl_pkg::in_t                 c_item;
  prl_pkg::ent_t                c_rx, c_rz, c_bkx;

  assign last = side[LAT-1];
  assign qx   = prl_pkg::SAT_W'(quo_x);
  assign qz   = prl_pkg::SAT_W'(quo_z);

  always_ff @(posedge clk) begin
    if (rst) begin
      c_v <= 1'b0;
    end else if (en) begin
      c_v <= last.v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_lev  <= last.lev;
      c_item <= last.item;
      c_rx   <= prl_pkg::sat16(last.item.back_z[prl_pkg::DATA_W-1] ? -qz : qz);
      c_rz   <= prl_pkg::sat16(last.item.back_x[prl_pkg::DATA_W-1] ? qx : -qx);
      c_bkx  <= prl_pkg::sat16(last.item.back_x[prl_pkg::DATA_W-1] ? -qx : qx);
    end
  end

  // stage d: cross product terms
  logic                              d_v, d_lev;
  prl_pkg::in_t                      d_item;
  prl_pkg::ent_t                     d_rx, d_rz, d_bkx;
  logic signed [prl_pkg::PROD_W-1:0] p_yz, p_zx, p_xz, p_yx;

  always_ff @(posedge clk) begin
    if (rst) begin
      d_v <= 1'b0;
    end else if (en) begin
      d_v <= c_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_lev  <= c_lev;
      d_item <= c_item;
      d_rx   <= c_rx;
      d_rz   <= c_rz;
      d_bkx  <= c_bkx;
      p_yz   <= c_item.back_y * c_rz;
      p_zx   <= c_item.back_z * c_rx;
      p_xz   <= c_item.back_x * c_rz;
      p_yx   <= c_item.back_y * c_rx;
    end
  end

  // stage e: result selection
  prl_pkg::out_t                    res;
  logic signed [prl_pkg::SAT_W-1:0] ux, uy, uz;

  always_comb begin
    ux = prl_pkg::SAT_W'(p_yz) >>> prl_pkg::FRAC_BITS;
    uy = (prl_pkg::SAT_W'(p_zx) - prl_pkg::SAT_W'(p_xz)) >>> prl_pkg::FRAC_BITS;
    uz = (-prl_pkg::SAT_W'(p_yx)) >>> prl_pkg::FRAC_BITS;
    res.new_right_x = d_item.right_x;
    res.new_right_y = d_item.right_y;
    res.new_right_z = d_item.right_z;
    res.new_up_x    = d_item.up_x;
    res.new_up_y    = d_item.up_y;
    res.new_up_z    = d_item.up_z;
    res.new_back_x  = d_item.back_x;
    res.new_back_y  = d_item.back_y;
    res.new_back_z  = d_item.back_z;
    res.leveled     = d_lev;
    if (d_lev) begin
      res.new_right_x = d_rx;
      res.new_right_y = '0;
      res.new_right_z = d_rz;
      if (!d_item.mode) begin
        res.new_up_x   = '0;
        res.new_up_y   = prl_pkg::UNIT_Q;
        res.new_up_z   = '0;
        res.new_back_x = d_bkx;
        res.new_back_y = '0;
        res.new_back_z = d_rx;
      end else begin
        res.new_up_x = prl_pkg::sat16(ux);
        res.new_up_y = prl_pkg::sat16(uy);
        res.new_up_z = prl_pkg::sat16(uz);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= d_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= res;
    end
  end

endmodule
`default_nettype wire

[src/prl_isqrt.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// prl_isqrt
// Pipelined floor square root, SQRT_PER result bits per stage.
// ----------------------------------------------------------------------------
module prl_isqrt (
  input  wire logic                        clk,
  input  wire logic                        en,
  input  wire logic [prl_pkg::SQ_W-1:0]    radicand,
  output logic      [prl_pkg::ROOT_W-1:0]  root
);

  prl_pkg::sqrt_st_t st[prl_pkg::SQRT_STAGES];

  for (genvar s = 0; s < prl_pkg::SQRT_STAGES; s++) begin : g_stage
    prl_pkg::sqrt_st_t nxt;
    always_comb begin
      if (s == 0) begin
        nxt = '{x: radicand, rem: '0, root: '0};
      end else begin
        nxt = st[(s == 0) ? 0 : s-1];
      end
      for (int k = 0; k < prl_pkg::SQRT_PER; k++) begin
        nxt = prl_pkg::sqrt_iter(nxt);
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        st[s] <= nxt;
      end
    end
  end

  assign root = st[prl_pkg::SQRT_STAGES-1].root;

endmodule
`default_nettype wire

[src/prl_div.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// prl_div
// Pipelined unsigned restoring divider, DIV_PER quotient bits per stage.
// ----------------------------------------------------------------------------
module prl_div (
  input  wire logic                         clk,
  input  wire logic                         en,
  input  wire logic [prl_pkg::NUM_PAD-1:0]  num,
  input  wire logic [prl_pkg::ROOT_W-1:0]   den,
  output logic      [prl_pkg::NUM_PAD-1:0]  quo
);

  prl_pkg::div_st_t          st[prl_pkg::DIV_STAGES];
  logic [prl_pkg::ROOT_W-1:0] den_r[prl_pkg::DIV_STAGES];

  for (genvar s = 0; s < prl_pkg::DIV_STAGES; s++) begin : g_stage
    prl_pkg::div_st_t           nxt;
    logic [prl_pkg::ROOT_W-1:0] d;
    always_comb begin
      if (s == 0) begin
        nxt = '{num: num, rem: '0, quo: '0};
        d   = den;
      end else begin
        nxt = st[(s == 0) ? 0 : s-1];
        d   = den_r[(s == 0) ? 0 : s-1];
      end
      for (int k = 0; k < prl_pkg::DIV_PER; k++) begin
        nxt = prl_pkg::div_iter(nxt, d);
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        st[s]    <= nxt;
        den_r[s] <= d;
      end
    end
  end

  assign quo = st[prl_pkg::DIV_STAGES-1].quo;

endmodule
`default_nettype wire
